FILE: rtl/scs_pkg.sv
// Shared types and constants for the source comment stripper.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package scs_pkg;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_CODE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_SLASH  = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_LINE   = 3'd4,
    MODE_HASH   = 3'd5,
    MODE_PASCAL = 3'd6
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_TEXT     = 2'd0,
    KIND_END_OK   = 2'd1,
    KIND_END_OPEN = 2'd2
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_STRIP_BLOCK  = 3'd0,
    CFG_STRIP_LINE   = 3'd1,
    CFG_CONVERT_LINE = 3'd2,
    CFG_STRIP_HASH   = 3'd3,
    CFG_STRIP_PASCAL = 3'd4,
    CFG_DROP_EMPTY   = 3'd5
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MAX_RES   = 4;   // results one byte can cause
  localparam int unsigned RES_CNT_W = 3;   // holds 0..MAX_RES
  localparam int unsigned QDEPTH    = 4;   // bundle queue entries
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  // Character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic strip_block;
    logic strip_line;
    logic convert_line;
    logic strip_hash;
    logic strip_pascal;
    logic drop_empty;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  // All results caused by one accepted byte
  typedef struct packed {
    logic [RES_CNT_W-1:0] count;
    res_t [MAX_RES-1:0]   slot;
  } bundle_t;

endpackage

`default_nettype wire

FILE: rtl/scs_front.sv
// Front end: configuration registers, scanner state and classification of each byte.
// Produces one bundle of up to four results per accepted byte. Uses scs_pkg.
`default_nettype none

module scs_front #(
  parameter int unsigned MAX_PASCAL_DEPTH = 255
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_valid,
  input  wire [scs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire                         cfg_data,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [7:0]                   in_text_byte,
  input  wire [7:0]                   in_lookahead_byte,
  input  wire                         in_is_final,
  input  wire                         q_full,
  output logic                        push,
  output scs_pkg::bundle_t            push_bundle
);
  import scs_pkg::*;

  localparam int unsigned DW = $clog2(MAX_PASCAL_DEPTH + 1);

  cfg_t          cfg_r;
  mode_t         mode_r, mode_nxt, hmode;
  logic          qdbl_r, qdbl_nxt;
  logic          esc_r, esc_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          brace_r, brace_nxt;
  logic          just_r, just_nxt;

  logic [7:0] b;
  logic       fin, la_star, is_quote, accept;
  logic       pas_close, pas_open, code_pascal, line_on;
  logic [7:0] close_q;

  assign b         = in_text_byte;
  assign fin       = in_is_final;
  assign la_star   = !fin && (in_lookahead_byte == CH_STAR);
  assign is_quote  = (b == CH_SQUOTE) || (b == CH_DQUOTE);
  assign close_q   = qdbl_r ? CH_DQUOTE : CH_SQUOTE;
  assign pas_close = ((prev_r == CH_STAR) && (b == CH_RPAREN)) || (brace_r && (b == CH_RBRACE));
  assign pas_open  = ((b == CH_LPAREN) && la_star) || (brace_r && (b == CH_LBRACE));
  assign code_pascal = cfg_r.strip_pascal &&
                       ((b == CH_LBRACE) || ((b == CH_LPAREN) && la_star));
  assign line_on   = cfg_r.strip_line || cfg_r.convert_line;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (push_bundle.count != '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{strip_block: 1'b1, strip_line: 1'b1, default: 1'b0};
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STRIP_BLOCK:  cfg_r.strip_block  <= cfg_data;
        CFG_STRIP_LINE:   cfg_r.strip_line   <= cfg_data;
        CFG_CONVERT_LINE: cfg_r.convert_line <= cfg_data;
        CFG_STRIP_HASH:   cfg_r.strip_hash   <= cfg_data;
        CFG_STRIP_PASCAL: cfg_r.strip_pascal <= cfg_data;
        CFG_DROP_EMPTY:   cfg_r.drop_empty   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    qdbl_nxt  = qdbl_r;
    esc_nxt   = esc_r;
    prev_nxt  = prev_r;
    depth_nxt = depth_r;
    brace_nxt = brace_r;
    just_nxt  = just_r;
    if (b != CH_CR) begin
      just_nxt = 1'b0;
      prev_nxt = b;
      unique case (mode_r)
        MODE_STRING: begin
          if (b == CH_BSLASH) begin
            esc_nxt = ~esc_r;
          end else begin
            if (is_quote && !esc_r && (b == close_q)) mode_nxt = MODE_CODE;
            esc_nxt = 1'b0;
          end
        end
        MODE_SLASH: begin
          if ((b == CH_STAR) && cfg_r.strip_block) begin
            mode_nxt = MODE_BLOCK;
            just_nxt = 1'b1;
          end else if ((b == CH_SLASH) && line_on) begin
            mode_nxt = MODE_LINE;
          end else begin
            mode_nxt = MODE_CODE;
          end
        end
        MODE_LINE, MODE_HASH: begin
          if (b == CH_NL) mode_nxt = MODE_CODE;
        end
        MODE_BLOCK: begin
          if ((b == CH_SLASH) && (prev_r == CH_STAR) && !just_r) mode_nxt = MODE_CODE;
        end
        MODE_PASCAL: begin
          if (pas_close) begin
            if (depth_r == '0) begin
              brace_nxt = 1'b0;
              mode_nxt  = MODE_CODE;
            end else begin
              depth_nxt = depth_r - DW'(1);
            end
          end else if (pas_open) begin
            if (depth_r < DW'(MAX_PASCAL_DEPTH)) depth_nxt = depth_r + DW'(1);
          end
        end
        default: begin
          if (is_quote) begin
            mode_nxt = MODE_STRING;
            qdbl_nxt = (b == CH_DQUOTE);
            esc_nxt  = 1'b0;
          end else if (b == CH_SLASH) begin
            mode_nxt = MODE_SLASH;
          end else if (cfg_r.strip_hash && (b == CH_HASH)) begin
            mode_nxt = MODE_HASH;
          end else if (code_pascal) begin
            brace_nxt = (b == CH_LBRACE);
            depth_nxt = '0;
            mode_nxt  = MODE_PASCAL;
          end
        end
      endcase
    end
    hmode = mode_nxt;
    if (fin) begin
      mode_nxt  = MODE_CODE;
      qdbl_nxt  = 1'b0;
      esc_nxt   = 1'b0;
      prev_nxt  = '0;
      depth_nxt = '0;
      brace_nxt = 1'b0;
      just_nxt  = 1'b0;
    end
  end

  // Outputs: the result bundle
  always_comb begin
    logic [RES_CNT_W-1:0] n;
    bundle_t              bnd;
    n   = '0;
    bnd = '0;
    if (b != CH_CR) begin
      unique case (mode_r)
        MODE_STRING: begin
          bnd.slot[n[1:0]] = '{KIND_TEXT, b}; n = n + 1'b1;
        end
        MODE_SLASH: begin
          if ((b == CH_STAR) && cfg_r.strip_block) begin
            n = n;
          end else if ((b == CH_SLASH) && line_on) begin
            if (cfg_r.convert_line) begin
              bnd.slot[n[1:0]] = '{KIND_TEXT, CH_SLASH}; n = n + 1'b1;
              bnd.slot[n[1:0]] = '{KIND_TEXT, CH_STAR};  n = n + 1'b1;
            end
          end else begin
            bnd.slot[n[1:0]] = '{KIND_TEXT, CH_SLASH}; n = n + 1'b1;
            bnd.slot[n[1:0]] = '{KIND_TEXT, b};        n = n + 1'b1;
          end
        end
        MODE_LINE, MODE_HASH: begin
          if (b == CH_NL) begin
            if ((mode_r == MODE_LINE) && cfg_r.convert_line) begin
              bnd.slot[n[1:0]] = '{KIND_TEXT, CH_STAR};  n = n + 1'b1;
              bnd.slot[n[1:0]] = '{KIND_TEXT, CH_SLASH}; n = n + 1'b1;
            end
            bnd.slot[n[1:0]] = '{KIND_TEXT, b}; n = n + 1'b1;
          end else if ((mode_r == MODE_LINE) && cfg_r.convert_line) begin
            bnd.slot[n[1:0]] = '{KIND_TEXT, b}; n = n + 1'b1;
          end
        end
        MODE_BLOCK, MODE_PASCAL: begin
          n = n;
        end
        default: begin
          if (is_quote) begin
            bnd.slot[n[1:0]] = '{KIND_TEXT, b}; n = n + 1'b1;
          end else if ((b == CH_SLASH) || (cfg_r.strip_hash && (b == CH_HASH)) ||
                       code_pascal) begin
            n = n;
          end else if (cfg_r.drop_empty && (b == CH_NL) && !fin &&
                       (in_lookahead_byte == CH_NL)) begin
            n = n;
          end else begin
            bnd.slot[n[1:0]] = '{KIND_TEXT, b}; n = n + 1'b1;
          end
        end
      endcase
    end
    if (fin) begin
      if (hmode == MODE_SLASH) begin
        bnd.slot[n[1:0]] = '{KIND_TEXT, CH_SLASH}; n = n + 1'b1;
      end
      bnd.slot[n[1:0]] = '{(hmode == MODE_STRING) ? KIND_END_OPEN : KIND_END_OK, 8'h00};
      n = n + 1'b1;
    end
    bnd.count   = n;
    push_bundle = bnd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_CODE;
      qdbl_r  <= 1'b0;
      esc_r   <= 1'b0;
      prev_r  <= '0;
      depth_r <= '0;
      brace_r <= 1'b0;
      just_r  <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      qdbl_r  <= qdbl_nxt;
      esc_r   <= esc_nxt;
      prev_r  <= prev_nxt;
      depth_r <= depth_nxt;
      brace_r <= brace_nxt;
      just_r  <= just_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/scs_queue.sv
// Short queue of result bundles between the front end and the output serializer.
// Uses scs_pkg for the bundle type and depth.
`default_nettype none

module scs_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  scs_pkg::bundle_t push_bundle,
  output logic             full,
  input  wire              pop,
  output logic             nonempty,
  output scs_pkg::bundle_t head
);
  import scs_pkg::*;

  bundle_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/scs_back.sv
// Back end: walks each queued bundle one result at a time into the output register.
// Uses scs_pkg for the bundle type.
`default_nettype none

module scs_back (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              q_nonempty,
  input  scs_pkg::bundle_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run
);
  import scs_pkg::*;

  logic        valid_r, valid_nxt;
  kind_t       kind_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [1:0]  idx_r, idx_nxt;
  logic        load, is_last;
  res_t        cur;

  assign cur     = q_head.slot[idx_r];
  assign is_last = ({1'b0, idx_r} + 1'b1) == q_head.count;
  assign load    = q_nonempty && (!valid_r || out_ready);
  assign q_pop   = load && is_last;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 2'd0 : idx_r + 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= cur.kind;
      byte_r <= cur.data;
      last_r <= is_last;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_byte        = byte_r;
  assign out_last_of_run = last_r;

endmodule

`default_nettype wire

FILE: rtl/source_comment_stripper.sv
// Top level of the source comment stripper: front end, bundle queue, output serializer.
// Depends on scs_pkg, scs_front, scs_queue and scs_back.
//
// The block takes source text one byte per transaction, each with the next non-CR byte as
// lookahead and a flag on the last byte of the stream, and returns the text with comments
// removed: slash-star, double-slash (or rewritten as slash-star), hash and nestable Pascal
// comments, each under its own enable bit, with quoted literals passed through intact and
// optional dropping of empty lines. CR bytes are ignored. On the last byte one end
// transaction follows the text, with kind 1, or kind 2 if a literal was left open; the
// scanner then returns to its reset state while the configuration bits stay. Every input
// byte is classified combinationally, so a new input transaction is taken every cycle
// while the four-entry bundle queue has room. Each input byte yields zero to four results,
// and the output register delivers one result per cycle while out_ready is high, so the
// sustained rate is one input byte per cycle as long as bytes average at most one result.
// Results go through the bundle queue, then leave the output register one at a time.
// Configuration writes are always ready and must only be issued while the block is idle.
// No clearing pass is needed after reset.
`default_nettype none

module source_comment_stripper #(
  parameter int unsigned MAX_PASCAL_DEPTH = 255
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // configuration write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [scs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire                          cfg_data,
  // input channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [7:0]                    in_text_byte,
  input  wire [7:0]                    in_lookahead_byte,
  input  wire                          in_is_final,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_byte,
  output logic                         out_last_of_run
);
  import scs_pkg::*;

  logic    q_full, q_nonempty, q_push, q_pop;
  bundle_t q_in, q_head;

  // Configuration lands in a register in the front end; never stall it.
  assign cfg_ready = 1'b1;

  // Classify each byte and build its result bundle.
  scs_front #(
    .MAX_PASCAL_DEPTH(MAX_PASCAL_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_lookahead_byte(in_lookahead_byte),
    .in_is_final      (in_is_final),
    .q_full           (q_full),
    .push             (q_push),
    .push_bundle      (q_in)
  );

  // Hold bundles so the front end keeps going while the output stalls.
  scs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_bundle(q_in),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  // Advance through each bundle one result per output transaction.
  scs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

endmodule

`default_nettype wire

FILE: rtl/scs_checker.sv
// Port-level checks on the result channel of the source comment stripper.
// Bound to source_comment_stripper; uses scs_pkg for the result kinds.
`default_nettype none

module scs_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_kind,
  input wire [7:0] out_byte,
  input wire       out_last_of_run
);
  import scs_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte) &&
      $stable(out_last_of_run))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Only the three defined kinds appear.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_TEXT) || (out_kind == KIND_END_OK) ||
      (out_kind == KIND_END_OPEN))
    else $error("undefined result kind");

  // An end result closes its run and carries a zero byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_TEXT |-> out_last_of_run && out_byte == 8'h00)
    else $error("end result not last or byte nonzero");

  // After an end result is taken, a following result that does not close its run must be text.
  a_no_double_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind != KIND_TEXT ##1 out_valid && !out_last_of_run
      |-> out_kind == KIND_TEXT)
    else $error("end result inside a run");

endmodule

bind source_comment_stripper scs_checker u_scs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_byte       (out_byte),
  .out_last_of_run(out_last_of_run)
);

`default_nettype wire
